[src/edidbb_pkg.sv]
// ----------------------------------------------------------------------------
// EDID base block parser package
// Shared constants, codes and types of the EDID base block parser.
// ----------------------------------------------------------------------------
package edidbb_pkg;

   localparam int TEXT_LEN = 12;
   localparam int LEN_W    = $clog2(TEXT_LEN + 1);
   localparam int IDX_W    = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1;
   localparam int K_W      = 5;

   localparam logic [LEN_W-1:0] TEXT_LEN_CNT = LEN_W'(TEXT_LEN);

   localparam logic [7:0] BASE_LEN      = 8'd128;
   localparam logic [7:0] POS_HDR0      = 8'h00;
   localparam logic [7:0] POS_HDR1      = 8'h01;
   localparam logic [7:0] POS_VENDOR_HI = 8'h08;
   localparam logic [7:0] POS_VENDOR_LO = 8'h09;
   localparam logic [7:0] SERIAL_FIRST  = 8'h0c;
   localparam logic [7:0] SERIAL_END    = 8'h10;
   localparam logic [7:0] DESC_FIRST    = 8'h36;
   localparam logic [7:0] DESC_END      = 8'h6c + 8'd18;

   localparam logic [K_W-1:0] K_VALID    = K_W'(0);
   localparam logic [K_W-1:0] K_PAD      = K_W'(2);
   localparam logic [K_W-1:0] K_TAG      = K_W'(3);
   localparam logic [K_W-1:0] K_TEXT     = K_W'(5);
   localparam logic [K_W-1:0] K_TEXT_END = K_W'(5 + TEXT_LEN);
   localparam logic [K_W-1:0] K_LAST     = K_W'(17);

   localparam logic [7:0] HDR0_VALUE  = 8'h00;
   localparam logic [7:0] HDR1_VALUE  = 8'hff;
   localparam logic [7:0] TAG_NAME    = 8'hfc;
   localparam logic [7:0] TAG_SERIAL  = 8'hff;
   localparam logic [7:0] TAG_ALNUM   = 8'hfe;
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] PRINT_LO    = 8'h20;
   localparam logic [7:0] PRINT_HI    = 8'h7e;
   localparam logic [7:0] CHAR_DASH   = 8'h2d;
   localparam logic [7:0] VENDOR_BASE = 8'h40;

   localparam logic [3:0] JUNK_RESET = 4'd4;
   localparam logic [3:0] REPL_MAX   = 4'hf;

   typedef enum logic [1:0] {
      DESC_NONE,
      DESC_NAME,
      DESC_SERIAL,
      DESC_ALNUM
   } desc_kind_type;

   typedef enum logic [1:0] {
      ITEM_SUMMARY,
      ITEM_NAME,
      ITEM_SERIAL,
      ITEM_ALNUM
   } item_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_SHORT,
      STATUS_BAD_HEADER
   } parse_status_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_SUMMARY,
      EM_TEXT
   } emit_state_type;

   typedef struct packed {
      logic             short_blob;
      logic             header_bad;
      logic [15:0]      vendor_bytes;
      logic [31:0]      serial_word;
      logic             serial_seen;
      logic [LEN_W-1:0] name_len;
      logic [LEN_W-1:0] serial_len;
      logic [LEN_W-1:0] alnum_len;
   } parse_info_type;

   typedef struct packed {
      logic [7:0] name_char;
      logic [7:0] serial_char;
      logic [7:0] alnum_char;
   } text_read_type;

   typedef struct packed {
      logic busy;
      logic clear;
   } emit_ctrl_type;

   typedef struct packed {
      item_kind_type    item_kind;
      parse_status_type parse_status;
      logic [7:0]       vendor_letter_a;
      logic [7:0]       vendor_letter_b;
      logic [7:0]       vendor_letter_c;
      logic [31:0]      numeric_serial;
      logic             serial_text_seen;
      logic [3:0]       text_length;
      logic [3:0]       text_index;
      logic [7:0]       text_char;
      logic             run_last;
   } rsp_word_type;

endpackage

[src/edidbb_if.sv]
// ----------------------------------------------------------------------------
// EDID base block parser channels
// Valid/ready channels for blob bytes and for parse results.
// ----------------------------------------------------------------------------
interface edidbb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blob_byte;
   logic       blob_end;

   modport source (output valid, output blob_byte, output blob_end, input ready);
   modport sink (input valid, input blob_byte, input blob_end, output ready);
endinterface

interface edidbb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  item_kind;
   logic [1:0]  parse_status;
   logic [7:0]  vendor_letter_a;
   logic [7:0]  vendor_letter_b;
   logic [7:0]  vendor_letter_c;
   logic [31:0] numeric_serial;
   logic        serial_text_seen;
   logic [3:0]  text_length;
   logic [3:0]  text_index;
   logic [7:0]  text_char;
   logic        run_last;

   modport source (
      output valid, output item_kind, output parse_status,
      output vendor_letter_a, output vendor_letter_b, output vendor_letter_c,
      output numeric_serial, output serial_text_seen, output text_length,
      output text_index, output text_char, output run_last, input ready
   );
   modport sink (
      input valid, input item_kind, input parse_status,
      input vendor_letter_a, input vendor_letter_b, input vendor_letter_c,
      input numeric_serial, input serial_text_seen, input text_length,
      input text_index, input text_char, input run_last, output ready
   );
endinterface

[src/edidbb_parse.sv]
// ----------------------------------------------------------------------------
// EDID base block parse stage
// Input register, per-byte field capture, descriptor text stores and the
// junk limit register.
// ----------------------------------------------------------------------------
module edidbb_parse
   import edidbb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [3:0]       csr_write_data,
   edidbb_req_if.sink       req_ch,
   input  emit_ctrl_type    emit_ctrl,
   input  logic [IDX_W-1:0] read_index,
   output parse_info_type   parse_info,
   output text_read_type    text_read,
   output logic             run_end
);

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_end_ff;
   logic [3:0]       junk_limit_ff;

   logic [7:0]       byte_position_ff, byte_position_in;
   logic             header_bad_ff, header_bad_in;
   logic [15:0]      vendor_bytes_ff, vendor_bytes_in;
   logic [31:0]      serial_word_ff, serial_word_in;
   logic [K_W-1:0]   desc_k_ff, desc_k_in;
   logic             desc_valid_ff, desc_valid_in;
   desc_kind_type    desc_kind_ff, desc_kind_in;
   logic             text_stopped_ff, text_stopped_in;
   logic [3:0]       replace_count_ff, replace_count_in;
   logic [LEN_W-1:0] cur_len_ff, cur_len_in;
   logic [LEN_W-1:0] name_len_ff, name_len_in;
   logic [LEN_W-1:0] serial_len_ff, serial_len_in;
   logic [LEN_W-1:0] alnum_len_ff, alnum_len_in;
   logic             serial_desc_ff, serial_desc_in;

   logic [7:0]       name_store_ff [TEXT_LEN];
   logic [7:0]       serial_store_ff [TEXT_LEN];
   logic [7:0]       alnum_store_ff [TEXT_LEN];

   logic             consume;
   logic             take;
   logic             in_desc;
   logic             store_we;
   logic [7:0]       store_char;
   logic [LEN_W-1:0] commit_len;
   logic [7:0]       b;

   assign consume      = in_valid_ff && !emit_ctrl.busy;
   assign req_ch.ready = !in_valid_ff || consume;
   assign run_end      = consume && in_end_ff;
   assign b            = in_byte_ff;
   assign take         = consume && (byte_position_ff < BASE_LEN);
   assign in_desc      = (byte_position_ff >= DESC_FIRST) && (byte_position_ff < DESC_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready) begin
         in_byte_ff <= req_ch.blob_byte;
         in_end_ff  <= req_ch.blob_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         junk_limit_ff <= JUNK_RESET;
      end else if (csr_write_enable) begin
         junk_limit_ff <= csr_write_data;
      end
   end

   always_comb begin
      byte_position_in = byte_position_ff;
      header_bad_in    = header_bad_ff;
      vendor_bytes_in  = vendor_bytes_ff;
      serial_word_in   = serial_word_ff;
      desc_k_in        = desc_k_ff;
      desc_valid_in    = desc_valid_ff;
      desc_kind_in     = desc_kind_ff;
      text_stopped_in  = text_stopped_ff;
      replace_count_in = replace_count_ff;
      cur_len_in       = cur_len_ff;
      name_len_in      = name_len_ff;
      serial_len_in    = serial_len_ff;
      alnum_len_in     = alnum_len_ff;
      serial_desc_in   = serial_desc_ff;
      store_we         = 1'b0;
      store_char       = b;
      commit_len       = '0;

      if (take) begin
         byte_position_in = byte_position_ff + 8'd1;
         if (byte_position_ff == POS_HDR0 && b != HDR0_VALUE) begin
            header_bad_in = 1'b1;
         end
         if (byte_position_ff == POS_HDR1 && b != HDR1_VALUE) begin
            header_bad_in = 1'b1;
         end
         if (byte_position_ff == POS_VENDOR_HI) begin
            vendor_bytes_in[15:8] = b;
         end
         if (byte_position_ff == POS_VENDOR_LO) begin
            vendor_bytes_in[7:0] = b;
         end
         if (byte_position_ff >= SERIAL_FIRST && byte_position_ff < SERIAL_END) begin
            serial_word_in[8*byte_position_ff[1:0] +: 8] = b;
         end

         if (in_desc) begin
            desc_k_in = (desc_k_ff == K_LAST) ? '0 : desc_k_ff + K_W'(1);

            if (desc_k_ff == K_VALID) begin
               desc_valid_in = (b == 8'h00);
            end else if (desc_k_ff == K_PAD) begin
               if (b != 8'h00) begin
                  desc_valid_in = 1'b0;
               end
            end else if (desc_k_ff == K_TAG) begin
               desc_kind_in = DESC_NONE;
               if (desc_valid_ff) begin
                  priority if (b == TAG_NAME) begin
                     desc_kind_in = DESC_NAME;
                  end else if (b == TAG_SERIAL) begin
                     desc_kind_in = DESC_SERIAL;
                  end else if (b == TAG_ALNUM) begin
                     desc_kind_in = DESC_ALNUM;
                  end else begin
                     desc_kind_in = DESC_NONE;
                  end
               end
               text_stopped_in  = 1'b0;
               replace_count_in = '0;
               cur_len_in       = '0;
            end

            if (desc_kind_ff != DESC_NONE && desc_k_ff >= K_TEXT &&
                desc_k_ff < K_TEXT_END && !text_stopped_ff) begin
               if (b == CHAR_NUL || b == CHAR_CR || b == CHAR_LF) begin
                  text_stopped_in = 1'b1;
               end else begin
                  if (b < PRINT_LO || b > PRINT_HI) begin
                     store_char = CHAR_DASH;
                     if (replace_count_ff != REPL_MAX) begin
                        replace_count_in = replace_count_ff + 4'd1;
                     end
                  end
                  if (cur_len_ff < TEXT_LEN_CNT) begin
                     store_we   = 1'b1;
                     cur_len_in = cur_len_ff + LEN_W'(1);
                  end
               end
            end

            if (desc_k_ff == K_LAST && desc_kind_ff != DESC_NONE) begin
               commit_len = (replace_count_in > junk_limit_ff) ? '0 : cur_len_in;
               unique case (desc_kind_ff)
                  DESC_NAME:   name_len_in = commit_len;
                  DESC_SERIAL: begin
                     serial_len_in  = commit_len;
                     serial_desc_in = 1'b1;
                  end
                  DESC_ALNUM:  alnum_len_in = commit_len;
                  default:     alnum_len_in = alnum_len_ff;
               endcase
               desc_kind_in = DESC_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || emit_ctrl.clear) begin
         byte_position_ff <= '0;
         header_bad_ff    <= 1'b0;
         vendor_bytes_ff  <= '0;
         serial_word_ff   <= '0;
         desc_k_ff        <= '0;
         desc_valid_ff    <= 1'b0;
         desc_kind_ff     <= DESC_NONE;
         text_stopped_ff  <= 1'b0;
         replace_count_ff <= '0;
         cur_len_ff       <= '0;
         name_len_ff      <= '0;
         serial_len_ff    <= '0;
         alnum_len_ff     <= '0;
         serial_desc_ff   <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         header_bad_ff    <= header_bad_in;
         vendor_bytes_ff  <= vendor_bytes_in;
         serial_word_ff   <= serial_word_in;
         desc_k_ff        <= desc_k_in;
         desc_valid_ff    <= desc_valid_in;
         desc_kind_ff     <= desc_kind_in;
         text_stopped_ff  <= text_stopped_in;
         replace_count_ff <= replace_count_in;
         cur_len_ff       <= cur_len_in;
         name_len_ff      <= name_len_in;
         serial_len_ff    <= serial_len_in;
         alnum_len_ff     <= alnum_len_in;
         serial_desc_ff   <= serial_desc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         unique case (desc_kind_ff)
            DESC_NAME:   name_store_ff[cur_len_ff[IDX_W-1:0]] <= store_char;
            DESC_SERIAL: serial_store_ff[cur_len_ff[IDX_W-1:0]] <= store_char;
            DESC_ALNUM:  alnum_store_ff[cur_len_ff[IDX_W-1:0]] <= store_char;
            default:     ;
         endcase
      end
   end

   assign text_read.name_char   = name_store_ff[read_index];
   assign text_read.serial_char = serial_store_ff[read_index];
   assign text_read.alnum_char  = alnum_store_ff[read_index];

   assign parse_info.short_blob   = (byte_position_ff < BASE_LEN);
   assign parse_info.header_bad   = header_bad_ff;
   assign parse_info.vendor_bytes = vendor_bytes_ff;
   assign parse_info.serial_word  = serial_word_ff;
   assign parse_info.serial_seen  = serial_desc_ff;
   assign parse_info.name_len     = name_len_ff;
   assign parse_info.serial_len   = serial_len_ff;
   assign parse_info.alnum_len    = alnum_len_ff;

endmodule

[src/edidbb_emit.sv]
// ----------------------------------------------------------------------------
// EDID base block result sequencer
// Walks the summary and, unless the blob is short or its header is bad, the
// three strings after the final byte and drives the result register.
// ----------------------------------------------------------------------------
module edidbb_emit
   import edidbb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             run_end,
   input  parse_info_type   parse_info,
   input  text_read_type    text_read,
   output logic [IDX_W-1:0] read_index,
   output emit_ctrl_type    emit_ctrl,
   edidbb_rsp_if.source     rsp_ch
);

   emit_state_type   state_ff, state_in;
   item_kind_type    kind_ff, kind_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff;
   rsp_word_type     word_ff, word_in;

   logic             load;
   logic             load_word;
   parse_status_type status;
   logic [LEN_W-1:0] cur_len;
   logic [7:0]       cur_char;
   logic             last_in_string;

   assign load = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (parse_info.short_blob) begin
         status = STATUS_SHORT;
      end else if (parse_info.header_bad) begin
         status = STATUS_BAD_HEADER;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      unique case (kind_ff)
         ITEM_NAME: begin
            cur_len  = parse_info.name_len;
            cur_char = text_read.name_char;
         end
         ITEM_SERIAL: begin
            cur_len  = parse_info.serial_len;
            cur_char = text_read.serial_char;
         end
         ITEM_ALNUM: begin
            cur_len  = parse_info.alnum_len;
            cur_char = text_read.alnum_char;
         end
         default: begin
            cur_len  = '0;
            cur_char = '0;
         end
      endcase
   end

   assign last_in_string = (cur_len == '0) || (LEN_W'(idx_ff) + LEN_W'(1) == cur_len);

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      idx_in          = idx_ff;
      load_word       = 1'b0;
      word_in         = '0;
      emit_ctrl.busy  = (state_ff != EM_IDLE);
      emit_ctrl.clear = 1'b0;

      unique case (state_ff)
         EM_IDLE: begin
            if (run_end) begin
               state_in = EM_SUMMARY;
            end
         end
         EM_SUMMARY: begin
            if (load) begin
               load_word            = 1'b1;
               word_in.item_kind    = ITEM_SUMMARY;
               word_in.parse_status = status;
               if (status != STATUS_OK) begin
                  word_in.run_last = 1'b1;
                  emit_ctrl.clear  = 1'b1;
                  state_in         = EM_IDLE;
               end else begin
                  word_in.vendor_letter_a  = VENDOR_BASE +
                                             {3'b000, parse_info.vendor_bytes[14:10]};
                  word_in.vendor_letter_b  = VENDOR_BASE +
                                             {3'b000, parse_info.vendor_bytes[9:5]};
                  word_in.vendor_letter_c  = VENDOR_BASE +
                                             {3'b000, parse_info.vendor_bytes[4:0]};
                  word_in.numeric_serial   = parse_info.serial_word;
                  word_in.serial_text_seen = parse_info.serial_seen;
                  state_in                 = EM_TEXT;
                  kind_in                  = ITEM_NAME;
                  idx_in                   = '0;
               end
            end
         end
         EM_TEXT: begin
            if (load) begin
               load_word           = 1'b1;
               word_in.item_kind   = kind_ff;
               word_in.text_length = 4'(cur_len);
               if (cur_len != '0) begin
                  word_in.text_index = 4'(idx_ff);
                  word_in.text_char  = cur_char;
               end
               if (last_in_string) begin
                  idx_in = '0;
                  unique case (kind_ff)
                     ITEM_NAME:   kind_in = ITEM_SERIAL;
                     ITEM_SERIAL: kind_in = ITEM_ALNUM;
                     default: begin
                        word_in.run_last = 1'b1;
                        emit_ctrl.clear  = 1'b1;
                        state_in         = EM_IDLE;
                     end
                  endcase
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = EM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         kind_ff      <= ITEM_SUMMARY;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         if (load) begin
            rsp_valid_ff <= load_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_word) begin
         word_ff <= word_in;
      end
   end

   assign read_index = idx_ff;

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.item_kind        = word_ff.item_kind;
   assign rsp_ch.parse_status     = word_ff.parse_status;
   assign rsp_ch.vendor_letter_a  = word_ff.vendor_letter_a;
   assign rsp_ch.vendor_letter_b  = word_ff.vendor_letter_b;
   assign rsp_ch.vendor_letter_c  = word_ff.vendor_letter_c;
   assign rsp_ch.numeric_serial   = word_ff.numeric_serial;
   assign rsp_ch.serial_text_seen = word_ff.serial_text_seen;
   assign rsp_ch.text_length      = word_ff.text_length;
   assign rsp_ch.text_index       = word_ff.text_index;
   assign rsp_ch.text_char        = word_ff.text_char;
   assign rsp_ch.run_last         = word_ff.run_last;

endmodule

[src/edid_base_block_parser.sv]
// ----------------------------------------------------------------------------
// EDID base block parser
// Parses an EDID blob given one byte per word and reports the header status,
// vendor id, numeric serial and the three descriptor strings.
// ----------------------------------------------------------------------------
// The req channel carries one blob byte per word with blob_end on the last
// byte. Bytes are taken at one per cycle while the sequencer is idle: each
// word is held in the input register and then folded into the parse state.
// After the final byte the rsp channel gives a summary word, then one word
// per character of the monitor name, serial text and alphanumeric strings
// (one word with text_length 0 for an empty string); run_last marks the end.
// A short blob or a bad header gives the summary word only.
// After the last byte the summary word passes the state and result registers;
// the rest follow one per cycle unless rsp stalls, up to 37 words in all.
// Meanwhile the input register holds at most one byte of the next blob.
// The result register is refilled in the cycle its word is taken, so a
// stalled rsp channel simply pauses the sequence; req_ch.ready then drops
// once the input register is full.
// Reset empties both registers, clears the parse state and sets junk_limit
// to 4. junk_limit is written through csr_write_enable and csr_write_data.
// ----------------------------------------------------------------------------
module edid_base_block_parser
   import edidbb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   edidbb_req_if.sink   req_ch,
   edidbb_rsp_if.source rsp_ch,
   input  logic         csr_write_enable,
   input  logic [3:0]   csr_write_data
);

   emit_ctrl_type    emit_ctrl;
   parse_info_type   parse_info;
   text_read_type    text_read;
   logic [IDX_W-1:0] read_index;
   logic             run_end;

   edidbb_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .emit_ctrl        (emit_ctrl),
      .read_index       (read_index),
      .parse_info       (parse_info),
      .text_read        (text_read),
      .run_end          (run_end)
   );

   edidbb_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .run_end    (run_end),
      .parse_info (parse_info),
      .text_read  (text_read),
      .read_index (read_index),
      .emit_ctrl  (emit_ctrl),
      .rsp_ch     (rsp_ch)
   );

endmodule

[src/edidbb_checker.sv]
// ----------------------------------------------------------------------------
// EDID base block parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module edidbb_checker
   import edidbb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  item_kind,
   input logic [1:0]  parse_status,
   input logic [31:0] numeric_serial,
   input logic        serial_text_seen,
   input logic [3:0]  text_length,
   input logic [3:0]  text_index,
   input logic [7:0]  text_char,
   input logic        run_last
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_kind) &&
      $stable(text_index) && $stable(text_char) && $stable(run_last))
      else $error("result word changed while stalled");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_kind == ITEM_SUMMARY && parse_status != STATUS_OK |-> run_last)
      else $error("error summary is not the last word");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_kind != ITEM_SUMMARY |->
      parse_status == STATUS_OK && numeric_serial == 32'd0 && !serial_text_seen &&
      (text_index < text_length || (text_length == 4'd0 && text_index == 4'd0)))
      else $error("character word fields out of place");

   a_summary_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_kind == ITEM_SUMMARY |->
      text_length == 4'd0 && text_index == 4'd0 && text_char == 8'd0)
      else $error("summary word carries text fields");

endmodule

bind edid_base_block_parser edidbb_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .item_kind        (rsp_ch.item_kind),
   .parse_status     (rsp_ch.parse_status),
   .numeric_serial   (rsp_ch.numeric_serial),
   .serial_text_seen (rsp_ch.serial_text_seen),
   .text_length      (rsp_ch.text_length),
   .text_index       (rsp_ch.text_index),
   .text_char        (rsp_ch.text_char),
   .run_last         (rsp_ch.run_last)
);
